// ===== src/idkh_pkg.sv =====
// Shared types, constants and helpers for the identifier key hash engine.
// Used by the multiplier unit and the top level.
`default_nettype none

package idkh_pkg;

    localparam int LENGTH_BITS = 16;

    localparam logic [31:0] SEED_W32   = 32'h5d65b59e;
    localparam logic [31:0] SEED_W64   = 32'h1f123bb5;
    localparam logic [31:0] SEED_PTR   = 32'hbeef31c7;
    localparam logic [31:0] SEED_BYTES = 32'h6a09e667;
    localparam logic [31:0] GOLDEN     = 32'h9e3779b9;
    localparam logic [31:0] FNV_PRIME  = 32'h01000193;
    localparam logic [31:0] FMIX_C1    = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2    = 32'hc2b2ae35;

    typedef enum logic [2:0] {
        CMD_EMPTY   = 3'd0,
        CMD_WORD32  = 3'd1,
        CMD_WORD64  = 3'd2,
        CMD_POINTER = 3'd3,
        CMD_BEGIN   = 3'd4,
        CMD_BYTE    = 3'd5
    } cmd_t;

    typedef struct packed {
        logic        en;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    function automatic logic [LENGTH_BITS-1:0] len_from_count(input logic [15:0] count);
        logic [LENGTH_BITS+15:0] wide;
        wide = {{LENGTH_BITS{1'b0}}, count};
        return wide[LENGTH_BITS-1:0];
    endfunction

    function automatic logic [31:0] fold64(input logic [63:0] v);
        return v[31:0] ^ v[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== src/idkh_if.sv =====
// Valid/ready channel interfaces for key beats and hash beats.
// Depends on nothing but the widths of the key and hash fields.
`default_nettype none

interface idkh_key_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [63:0] word_value;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;

    modport source (output valid, command, word_value, byte_count, data_byte, input ready);
    modport sink (input valid, command, word_value, byte_count, data_byte, output ready);
endinterface

interface idkh_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink (input valid, hash_value, output ready);
endinterface

`default_nettype wire

// ===== src/idkh_mul_unit.sv =====
// Shared 32 by 32 multiplier keeping the low product word in a register.
// Depends on idkh_pkg for the request struct.
`default_nettype none

module idkh_mul_unit (
    input  wire logic              clk,
    input  wire idkh_pkg::mul_req_t req,
    output logic [31:0]            product
);

    logic [31:0] low_product;
    logic [31:0] product_reg;

    assign low_product = req.a * req.b;
    assign product     = product_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            product_reg <= low_product;
        end
    end

endmodule

`default_nettype wire

// ===== src/id_key_hash_engine.sv =====
// Identifier key hash engine: sequencer around one shared multiplier unit.
// Depends on idkh_pkg, idkh_if and idkh_mul_unit.
// Word keys run S_GOLD, S_FMIX1, S_FMIX2 and S_FIN; an empty key goes straight to S_FIN.
// A zero-length begin runs S_FMIX1, S_FMIX2, S_FIN; a byte runs S_FNV and S_FNV_WB, then the last one the fmix states.
// A stalled hash output holds the sequencer in its final state.
// Reset clears the sequencer, the open string and the output; pointer_is_wide resets to 1.
`default_nettype none

module id_key_hash_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    idkh_key_if.sink   key_in,
    idkh_hash_if.source hash_out,
    input  wire logic  cfg_write_en,
    input  wire logic  cfg_write_data
);

    localparam int LB = idkh_pkg::LENGTH_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GOLD,
        S_FMIX1,
        S_FMIX2,
        S_FIN,
        S_FNV,
        S_FNV_WB
    } state_t;

    state_t            state_reg, state_next;
    logic              pointer_is_wide_reg;
    logic [31:0]       acc_reg, acc_next;
    logic [31:0]       seed_reg, seed_next;
    logic [31:0]       running_hash_reg, running_hash_next;
    logic [LB-1:0]     bytes_left_reg, bytes_left_next;
    logic              string_open_reg, string_open_next;
    logic              from_string_reg, from_string_next;
    logic              zero_reg, zero_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_hash_reg, out_hash_next;

    idkh_pkg::mul_req_t mul_req;
    logic [31:0]        product;
    logic [31:0]        fmix_in;
    logic [31:0]        step1;
    logic [LB-1:0]      len;
    logic               accept;
    idkh_pkg::cmd_t     cmd;

    idkh_mul_unit u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    assign key_in.ready        = (state_reg == S_IDLE);
    assign accept              = key_in.valid && key_in.ready;
    assign cmd                 = idkh_pkg::cmd_t'(key_in.command);
    assign len                 = idkh_pkg::len_from_count(key_in.byte_count);
    assign hash_out.valid      = out_valid_reg;
    assign hash_out.hash_value = out_hash_reg;

    assign fmix_in = from_string_reg ? running_hash_reg : (product ^ seed_reg);
    assign step1   = fmix_in ^ (fmix_in >> 16);

    always_comb
    begin
        state_next        = state_reg;
        acc_next          = acc_reg;
        seed_next         = seed_reg;
        running_hash_next = running_hash_reg;
        bytes_left_next   = bytes_left_reg;
        string_open_next  = string_open_reg;
        from_string_next  = from_string_reg;
        zero_next         = zero_reg;
        out_valid_next    = out_valid_reg && !hash_out.ready;
        out_hash_next     = out_hash_reg;
        mul_req.en        = 1'b0;
        mul_req.a         = acc_reg;
        mul_req.b         = idkh_pkg::GOLDEN;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        idkh_pkg::CMD_EMPTY:
                        begin
                            zero_next  = 1'b1;
                            state_next = S_FIN;
                        end
                        idkh_pkg::CMD_WORD32:
                        begin
                            acc_next         = key_in.word_value[31:0];
                            seed_next        = idkh_pkg::SEED_W32;
                            zero_next        = 1'b0;
                            from_string_next = 1'b0;
                            state_next       = S_GOLD;
                        end
                        idkh_pkg::CMD_WORD64:
                        begin
                            acc_next         = idkh_pkg::fold64(key_in.word_value);
                            seed_next        = idkh_pkg::SEED_W64;
                            zero_next        = 1'b0;
                            from_string_next = 1'b0;
                            state_next       = S_GOLD;
                        end
                        idkh_pkg::CMD_POINTER:
                        begin
                            acc_next         = pointer_is_wide_reg
                                             ? idkh_pkg::fold64(key_in.word_value)
                                             : key_in.word_value[31:0];
                            seed_next        = idkh_pkg::SEED_PTR;
                            zero_next        = 1'b0;
                            from_string_next = 1'b0;
                            state_next       = S_GOLD;
                        end
                        idkh_pkg::CMD_BEGIN:
                        begin
                            running_hash_next = idkh_pkg::SEED_BYTES ^ {{(32-LB){1'b0}}, len};
                            bytes_left_next   = len;
                            if (len == '0)
                            begin
                                string_open_next = 1'b0;
                                from_string_next = 1'b1;
                                zero_next        = 1'b0;
                                state_next       = S_FMIX1;
                            end
                            else
                            begin
                                string_open_next = 1'b1;
                            end
                        end
                        idkh_pkg::CMD_BYTE:
                        begin
                            if (string_open_reg)
                            begin
                                acc_next   = {24'd0, key_in.data_byte};
                                state_next = S_FNV;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_GOLD:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = acc_reg;
                mul_req.b  = idkh_pkg::GOLDEN;
                state_next = S_FMIX1;
            end
            S_FMIX1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = step1;
                mul_req.b  = idkh_pkg::FMIX_C1;
                state_next = S_FMIX2;
            end
            S_FMIX2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = product ^ (product >> 13);
                mul_req.b  = idkh_pkg::FMIX_C2;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || hash_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = zero_reg ? 32'd0 : (product ^ (product >> 16));
                    state_next     = S_IDLE;
                end
            end
            S_FNV:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = running_hash_reg ^ acc_reg;
                mul_req.b  = idkh_pkg::FNV_PRIME;
                state_next = S_FNV_WB;
            end
            S_FNV_WB:
            begin
                running_hash_next = product;
                bytes_left_next   = bytes_left_reg - LB'(1);
                if (bytes_left_reg == LB'(1))
                begin
                    string_open_next = 1'b0;
                    from_string_next = 1'b1;
                    zero_next        = 1'b0;
                    state_next       = S_FMIX1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            pointer_is_wide_reg <= 1'b1;
            acc_reg             <= '0;
            seed_reg            <= '0;
            running_hash_reg    <= '0;
            bytes_left_reg      <= '0;
            string_open_reg     <= 1'b0;
            from_string_reg     <= 1'b0;
            zero_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
            out_hash_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            acc_reg          <= acc_next;
            seed_reg         <= seed_next;
            running_hash_reg <= running_hash_next;
            bytes_left_reg   <= bytes_left_next;
            string_open_reg  <= string_open_next;
            from_string_reg  <= from_string_next;
            zero_reg         <= zero_next;
            out_valid_reg    <= out_valid_next;
            out_hash_reg     <= out_hash_next;
            if (cfg_write_en)
            begin
                pointer_is_wide_reg <= cfg_write_data;
            end
        end
    end

    // An open string always has bytes outstanding.
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        string_open_reg |-> (bytes_left_reg != '0))
        else $error("open string with no bytes left");

    a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && (!out_valid_reg || hash_out.ready)) |=> out_valid_reg)
        else $error("finished hash not presented");

    a_word_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == idkh_pkg::CMD_WORD32 || cmd == idkh_pkg::CMD_WORD64
                    || cmd == idkh_pkg::CMD_POINTER)) |=> (state_reg == S_GOLD))
        else $error("word key did not start the golden multiply");

    a_zero_len_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == idkh_pkg::CMD_BEGIN && len == '0)
        |=> (state_reg == S_FMIX1 && !string_open_reg && from_string_reg))
        else $error("zero-length string not finished at once");

    a_last_byte_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FNV_WB && bytes_left_reg == LB'(1)) |=> !string_open_reg)
        else $error("string left open after its last byte");

endmodule

`default_nettype wire
